FILE: rtl/core/afsl_pkg.sv
`default_nettype none

package afsl_pkg;

  // Calibration table storage, sized for the largest table the block supports
  localparam int unsigned MAX_POINTS = 16;
  localparam int unsigned TAB_IDX_W  = 4;

  // Internal word widths of the fixed-point datapath (24 fraction bits)
  localparam int unsigned V_W    = 27;  // divider voltage
  localparam int unsigned NUM_W  = 32;  // resistance numerator
  localparam int unsigned DIV_W  = 31;  // divider remainder, divisor and quotient
  localparam int unsigned INV_W  = 24;  // reciprocal resistance
  localparam int unsigned KG_W   = 27;  // interpolated mass
  localparam int unsigned MUL_W  = 32;  // shared multiplier operand width
  localparam int unsigned PROD_W = 64;  // shared multiplier product width

  // Result field widths
  localparam int unsigned UV_W    = 22;
  localparam int unsigned OHM_W   = 17;
  localparam int unsigned MN_W    = 16;
  localparam int unsigned CLAMP_W = 2;
  localparam int unsigned OUT_DATA_W = 80;

  // Q24 constants, truncated
  localparam logic [MUL_W-1:0] Q24_C3_3     = 32'd55364812;
  localparam logic [MUL_W-1:0] Q24_C45_3    = 32'd760007884;
  localparam logic [NUM_W-1:0] Q24_C7_0215  = 32'd117801222;
  localparam logic [V_W-1:0]   Q24_C4_795   = 27'd80446750;
  localparam logic [V_W-1:0]   Q24_C4_794   = 27'd80429973;
  localparam logic [MUL_W-1:0] Q24_C9_80665 = 32'd164528285;

  // Integer scale factors
  localparam logic [MUL_W-1:0] SCALE_MILLI = 32'd1000;
  localparam logic [MUL_W-1:0] SCALE_MICRO = 32'd1000000;

  // Saturation limits
  localparam logic [OHM_W-1:0] OHM_MAX = 17'd131071;
  localparam logic [MN_W-1:0]  MN_MAX  = 16'd65535;

  // Table clamp codes
  localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
  localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd1;
  localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd2;

  // Calibration table: reciprocal resistance (1/kOhm, Q24) against mass (kg, Q24)
  localparam logic [INV_W-1:0] INV_TAB [MAX_POINTS] = '{
    24'd186411,  24'd372823,  24'd645285,  24'd986902,  24'd1398095,
    24'd1864133, 24'd2298243, 24'd2796208, 24'd3226392, 24'd3728266,
    24'd3728266, 24'd3728266, 24'd3728266, 24'd3728266, 24'd3728266,
    24'd3728266
  };

  localparam logic [KG_W-1:0] KG_TAB [MAX_POINTS] = '{
    27'd8388608,  27'd16777216, 27'd25165824, 27'd33554432, 27'd41943040,
    27'd50331648, 27'd58720256, 27'd67108864, 27'd75497472, 27'd83886080,
    27'd83886080, 27'd83886080, 27'd83886080, 27'd83886080, 27'd83886080,
    27'd83886080
  };

endpackage

`default_nettype wire

FILE: rtl/core/adc_force_sensor_linearizer_unit.sv
`default_nettype none

// Force-sensor linearizer. Takes one ADC code of a force-sensing-resistor divider
// on the slave stream and returns one result item on the master stream: divider
// voltage (uV), sensor resistance (ohm), reciprocal resistance (1/kOhm, Q24), force
// (mN, floored at zero) and a table clamp code in tuser. An item passes through a
// shared one-bit-per-cycle restoring divider that runs up to three divisions (31,
// 24 and 24 steps), the segment search, which tests one segment per cycle, and a
// handful of steps through the single shared 32x32 multiplier. A reciprocal that is
// clamped to a table end skips the search and the last division, and one lying
// exactly on a table point skips the last division. The input is not ready while
// an item is in work and is ready again in the cycle after the result is loaded; a
// finished result waits in the output register, so a new item may be taken before
// the previous result is collected, and that next item then waits in its last step
// until the register is free.
module adc_force_sensor_linearizer_unit #(
  parameter int unsigned TABLE_POINTS = 10,
  parameter int unsigned ADC_BITS     = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Slave stream
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata: ad_code, zero padded to whole bytes
  input  logic [((ADC_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // Master stream
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // tdata: voltage_uv[21:0], resistance_ohm[38:22], inv_r_q24[62:39],
  //        force_mn[78:63], zero pad[79]
  output logic [afsl_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  // tuser: table_clamp[1:0]
  output logic [afsl_pkg::CLAMP_W-1:0]          m_axis_tuser_o
);

  localparam int unsigned SEG_W = (TABLE_POINTS > 2) ? $clog2(TABLE_POINTS - 1) : 1;
  localparam logic [afsl_pkg::TAB_IDX_W-1:0] LAST_IDX =
    afsl_pkg::TAB_IDX_W'(TABLE_POINTS - 1);
  localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(TABLE_POINTS - 2);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_VMUL   = 4'd1;
  localparam logic [3:0] S_VCLAMP = 4'd2;
  localparam logic [3:0] S_NMUL   = 4'd3;
  localparam logic [3:0] S_UVMUL  = 4'd4;
  localparam logic [3:0] S_RLOAD  = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_OHM    = 4'd7;
  localparam logic [3:0] S_ILOAD  = 4'd8;
  localparam logic [3:0] S_RANGE  = 4'd9;
  localparam logic [3:0] S_SEARCH = 4'd10;
  localparam logic [3:0] S_IMUL   = 4'd11;
  localparam logic [3:0] S_IADD   = 4'd12;
  localparam logic [3:0] S_NEWT   = 4'd13;
  localparam logic [3:0] S_MNMUL  = 4'd14;
  localparam logic [3:0] S_EMIT   = 4'd15;

  // Divider step counts
  localparam logic [4:0] DIV_STEPS_R = 5'd31;
  localparam logic [4:0] DIV_STEPS_Q = 5'd24;

  logic [3:0] state_q, state_d;
  logic [3:0] ret_q, ret_d;
  logic       out_valid_q, out_valid_d;

  logic [ADC_BITS-1:0]              code_q;
  logic [afsl_pkg::V_W-1:0]         v_q;
  logic [afsl_pkg::NUM_W-1:0]       num_q;
  logic [afsl_pkg::UV_W-1:0]        uv_q;
  logic [afsl_pkg::DIV_W-1:0]       r_q;
  logic [afsl_pkg::OHM_W-1:0]       ohm_q;
  logic [afsl_pkg::INV_W-1:0]       inv_q;
  logic [afsl_pkg::KG_W-1:0]        kg_q;
  logic [afsl_pkg::CLAMP_W-1:0]     clamp_q;
  logic [SEG_W-1:0]                 seg_q;
  logic [afsl_pkg::PROD_W-1:0]      prod_q;
  logic [afsl_pkg::OUT_DATA_W-1:0]  out_data_q;
  logic [afsl_pkg::CLAMP_W-1:0]     out_user_q;

  // Divider registers
  logic [afsl_pkg::DIV_W-1:0] rem_q;
  logic [afsl_pkg::DIV_W-1:0] dbits_q;
  logic [afsl_pkg::DIV_W-1:0] dvs_q;
  logic [afsl_pkg::DIV_W-1:0] quot_q;
  logic [4:0]                 cnt_q;

  // Shared multiplier operands
  logic                        mul_en;
  logic [afsl_pkg::MUL_W-1:0]  mul_a, mul_b;

  // Divider step
  logic [afsl_pkg::DIV_W:0]    div_shift;
  logic [afsl_pkg::DIV_W:0]    div_diff;
  logic                        div_ge;
  logic [afsl_pkg::DIV_W-1:0]  div_rem_next;

  // Table segment values
  logic [afsl_pkg::TAB_IDX_W-1:0] seg_idx, seg_idx_nx;
  logic [afsl_pkg::INV_W-1:0]     seg_x0, seg_x1;
  logic [afsl_pkg::KG_W-1:0]      seg_y0, seg_y1, seg_ydiff;
  logic                           seg_up;
  logic                           seg_hit;
  logic                           seg_top;

  // Derived values
  logic [afsl_pkg::V_W-1:0]   v_raw;
  logic [afsl_pkg::INV_W-1:0] quot_inv;
  logic [afsl_pkg::KG_W-1:0]  interp_q;
  logic [afsl_pkg::KG_W-1:0]  kg_interp;
  logic [afsl_pkg::OHM_W-1:0] ohm_sat;
  logic [afsl_pkg::MN_W-1:0]  mn_sat;
  logic                       out_load;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // Divider: shift in one dividend bit, subtract when it fits
  assign div_shift    = {rem_q, dbits_q[afsl_pkg::DIV_W-1]};
  assign div_diff     = div_shift - {1'b0, dvs_q};
  assign div_ge       = (div_shift >= {1'b0, dvs_q});
  assign div_rem_next = div_ge ? div_diff[afsl_pkg::DIV_W-1:0]
                               : div_shift[afsl_pkg::DIV_W-1:0];

  // Look up the current calibration segment
  assign seg_idx    = afsl_pkg::TAB_IDX_W'(seg_q);
  assign seg_idx_nx = seg_idx + afsl_pkg::TAB_IDX_W'(1);
  assign seg_x0     = afsl_pkg::INV_TAB[seg_idx];
  assign seg_x1     = afsl_pkg::INV_TAB[seg_idx_nx];
  assign seg_y0     = afsl_pkg::KG_TAB[seg_idx];
  assign seg_y1     = afsl_pkg::KG_TAB[seg_idx_nx];
  assign seg_up     = (seg_y1 >= seg_y0);
  assign seg_ydiff  = seg_up ? (seg_y1 - seg_y0) : (seg_y0 - seg_y1);
  assign seg_hit    = (seg_x1 > seg_x0) && (inv_q >= seg_x0) && (inv_q <= seg_x1);
  // A reciprocal on the upper end of its segment gives the end value itself
  assign seg_top    = (inv_q == seg_x1);

  // Slice and saturate products
  assign v_raw    = prod_q[ADC_BITS +: afsl_pkg::V_W];
  assign quot_inv = quot_q[afsl_pkg::INV_W-1:0];
  assign interp_q = prod_q[24 +: afsl_pkg::KG_W];
  assign ohm_sat  = (|prod_q[afsl_pkg::PROD_W-1:24+afsl_pkg::OHM_W]) ? afsl_pkg::OHM_MAX
                  : prod_q[24 +: afsl_pkg::OHM_W];
  assign mn_sat   = (|prod_q[afsl_pkg::PROD_W-1:24+afsl_pkg::MN_W]) ? afsl_pkg::MN_MAX
                  : prod_q[24 +: afsl_pkg::MN_W];

  // Interpolate along the segment, flooring a falling segment at zero
  always_comb begin
    if (seg_up) begin
      kg_interp = seg_y0 + interp_q;
    end else if (interp_q >= seg_y0) begin
      kg_interp = '0;
    end else begin
      kg_interp = seg_y0 - interp_q;
    end
  end

  // Select multiplier operands by step
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_VMUL: begin
        mul_a = afsl_pkg::MUL_W'(code_q);
        mul_b = afsl_pkg::Q24_C3_3;
      end
      S_NMUL: begin
        mul_a = afsl_pkg::MUL_W'(v_q);
        mul_b = afsl_pkg::Q24_C45_3;
      end
      S_UVMUL: begin
        mul_a = afsl_pkg::MUL_W'(v_q);
        mul_b = afsl_pkg::SCALE_MICRO;
      end
      S_OHM: begin
        mul_a = afsl_pkg::MUL_W'(quot_q);
        mul_b = afsl_pkg::SCALE_MILLI;
      end
      S_IMUL: begin
        mul_a = afsl_pkg::MUL_W'(quot_inv);
        mul_b = afsl_pkg::MUL_W'(seg_ydiff);
      end
      S_NEWT: begin
        mul_a = afsl_pkg::MUL_W'(kg_q);
        mul_b = afsl_pkg::Q24_C9_80665;
      end
      S_MNMUL: begin
        mul_a = afsl_pkg::MUL_W'(prod_q[54:24]);
        mul_b = afsl_pkg::SCALE_MILLI;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready_i);

  // Sequence the steps of one item
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE:   if (s_axis_tvalid_i) state_d = S_VMUL;
      S_VMUL:   state_d = S_VCLAMP;
      S_VCLAMP: state_d = S_NMUL;
      S_NMUL:   state_d = S_UVMUL;
      S_UVMUL:  state_d = S_RLOAD;
      S_RLOAD: begin
        ret_d   = S_OHM;
        state_d = S_DIV;
      end
      S_DIV:    if (cnt_q == 5'd1) state_d = ret_q;
      S_OHM:    state_d = S_ILOAD;
      S_ILOAD: begin
        ret_d   = S_RANGE;
        state_d = S_DIV;
      end
      S_RANGE: begin
        if (quot_inv <= afsl_pkg::INV_TAB[0] || quot_inv >= afsl_pkg::INV_TAB[LAST_IDX]) begin
          state_d = S_NEWT;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (seg_hit && seg_top) begin
          state_d = S_NEWT;
        end else if (seg_hit) begin
          ret_d   = S_IMUL;
          state_d = S_DIV;
        end else if (seg_q == SEG_LAST) begin
          state_d = S_NEWT;
        end
      end
      S_IMUL:   state_d = S_IADD;
      S_IADD:   state_d = S_NEWT;
      S_NEWT:   state_d = S_MNMUL;
      S_MNMUL:  state_d = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    unique case (state_q)
      S_IDLE: begin
        code_q <= s_axis_tdata_i[ADC_BITS-1:0];
      end
      S_VCLAMP: begin
        v_q <= (v_raw >= afsl_pkg::Q24_C4_795) ? afsl_pkg::Q24_C4_794 : v_raw;
      end
      S_UVMUL: begin
        num_q <= prod_q[24 +: afsl_pkg::NUM_W] + afsl_pkg::Q24_C7_0215;
      end
      S_RLOAD: begin
        uv_q    <= prod_q[24 +: afsl_pkg::UV_W];
        rem_q   <= afsl_pkg::DIV_W'(num_q[afsl_pkg::NUM_W-1:7]);
        dbits_q <= {num_q[6:0], 24'd0};
        dvs_q   <= afsl_pkg::DIV_W'(afsl_pkg::Q24_C4_795 - v_q);
        quot_q  <= '0;
        cnt_q   <= DIV_STEPS_R;
      end
      S_DIV: begin
        rem_q   <= div_rem_next;
        dbits_q <= {dbits_q[afsl_pkg::DIV_W-2:0], 1'b0};
        quot_q  <= {quot_q[afsl_pkg::DIV_W-2:0], div_ge};
        cnt_q   <= cnt_q - 5'd1;
      end
      S_OHM: begin
        r_q <= quot_q;
      end
      S_ILOAD: begin
        ohm_q   <= ohm_sat;
        rem_q   <= afsl_pkg::DIV_W'(25'h1000000);
        dbits_q <= '0;
        dvs_q   <= r_q;
        quot_q  <= '0;
        cnt_q   <= DIV_STEPS_Q;
      end
      S_RANGE: begin
        inv_q <= quot_inv;
        seg_q <= '0;
        if (quot_inv <= afsl_pkg::INV_TAB[0]) begin
          kg_q    <= afsl_pkg::KG_TAB[0];
          clamp_q <= afsl_pkg::CLAMP_LOW;
        end else if (quot_inv >= afsl_pkg::INV_TAB[LAST_IDX]) begin
          kg_q    <= afsl_pkg::KG_TAB[LAST_IDX];
          clamp_q <= afsl_pkg::CLAMP_HIGH;
        end else begin
          clamp_q <= afsl_pkg::CLAMP_NONE;
        end
      end
      S_SEARCH: begin
        if (seg_hit && seg_top) begin
          kg_q <= seg_y1;
        end else if (seg_hit) begin
          rem_q   <= afsl_pkg::DIV_W'(inv_q - seg_x0);
          dbits_q <= '0;
          dvs_q   <= afsl_pkg::DIV_W'(seg_x1 - seg_x0);
          quot_q  <= '0;
          cnt_q   <= DIV_STEPS_Q;
        end else if (seg_q == SEG_LAST) begin
          kg_q <= afsl_pkg::KG_TAB[0];
        end else begin
          seg_q <= seg_q + SEG_W'(1);
        end
      end
      S_IADD: begin
        kg_q <= kg_interp;
      end
      S_EMIT: begin
        if (out_load) begin
          out_data_q <= {1'b0, mn_sat, inv_q, ohm_q, uv_q};
          out_user_q <= clamp_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/afsl_checker.sv
`default_nettype none

module afsl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [afsl_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [afsl_pkg::CLAMP_W-1:0]    m_axis_tuser_o
);

  // Drop ready once an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready did not drop after an item was taken");

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result withdrawn or changed while stalled");

  // Clamp code is one of the three defined outcomes
  a_clamp_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == afsl_pkg::CLAMP_NONE ||
                         m_axis_tuser_o == afsl_pkg::CLAMP_LOW ||
                         m_axis_tuser_o == afsl_pkg::CLAMP_HIGH))
    else $error("undefined table clamp code");

  // Voltage stays at or below full scale and the pad bit stays clear
  a_voltage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[21:0] <= 22'd3300000) && !m_axis_tdata_o[79])
    else $error("voltage beyond full scale or pad bit set");

endmodule

bind adc_force_sensor_linearizer_unit afsl_checker u_afsl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

FILE: sim/tb_adc_force_sensor_linearizer_unit.sv
`timescale 1ns / 100ps

module tb_adc_force_sensor_linearizer_unit;

  localparam int unsigned ADC_W         = 12;
  localparam int unsigned IN_DATA_W     = ((ADC_W + 7) / 8) * 8;
  localparam int unsigned CAL_POINTS    = 10;
  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned HOLD_OFF      = 700;
  localparam int unsigned HOLD_OFF_AT   = 300;
  localparam int unsigned DRAIN_CYCLES  = 150;
  localparam int unsigned WATCHDOG_MAX  = 4000;
  localparam int unsigned DIR_ROWS      = 17;

  // Q24 constants of the conversion chain, truncated
  localparam logic [63:0] VREF_Q24   = 64'd55364812;   // 3.3
  localparam logic [63:0] GAIN_Q24   = 64'd760007884;  // 45.3
  localparam logic [63:0] OFFS_Q24   = 64'd117801222;  // 7.0215
  localparam logic [63:0] VTOP_Q24   = 64'd80446750;   // 4.795
  localparam logic [63:0] VSAFE_Q24  = 64'd80429973;   // 4.794
  localparam logic [63:0] GRAV_Q24   = 64'd164528285;  // 9.80665
  localparam logic [63:0] MOHM_LIMIT = 64'd131071;
  localparam logic [63:0] MN_LIMIT   = 64'd65535;

  typedef logic [afsl_pkg::CLAMP_W-1:0] clamp_t;

  typedef struct packed {
    logic [21:0] uv;
    logic [16:0] ohm;
    logic [23:0] inv_r;
    logic [15:0] mn;
    clamp_t      clamp;
  } reading_t;

  // Directed row: code, and where typed, the clamp code and force read off the table ends
  typedef struct packed {
    logic [ADC_W-1:0] code;
    logic             typed;
    clamp_t           clamp;
    logic [15:0]      mn;
  } code_row_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               s_valid;
  logic [IN_DATA_W-1:0]               s_data;
  logic                               s_ready;
  logic                               m_valid;
  logic                               m_ready;
  logic [afsl_pkg::OUT_DATA_W-1:0]    m_data;
  clamp_t                             m_user;

  reading_t    readings_q [$];
  int unsigned err_cnt;
  int unsigned idle_cycles;

  adc_force_sensor_linearizer_unit #(
    .TABLE_POINTS(CAL_POINTS),
    .ADC_BITS    (ADC_W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  // Calibration points: reciprocal resistance (1/kOhm) and mass (kg), both Q24
  function automatic logic [63:0] cal_inv(int unsigned idx);
    case (idx)
      0:       return 64'd186411;
      1:       return 64'd372823;
      2:       return 64'd645285;
      3:       return 64'd986902;
      4:       return 64'd1398095;
      5:       return 64'd1864133;
      6:       return 64'd2298243;
      7:       return 64'd2796208;
      8:       return 64'd3226392;
      default: return 64'd3728266;
    endcase
  endfunction

  function automatic logic [63:0] cal_kg(int unsigned idx);
    if (idx > 9) begin
      return 64'd83886080;
    end
    return 64'd8388608 * (idx + 1);
  endfunction

  // Convert one ADC code into the full sensor reading
  function automatic reading_t linearize_code(logic [ADC_W-1:0] code);
    logic [63:0] volt, num, res, inv, kg, frac, newton, mn, ohm;
    logic [63:0] x0, x1, y0, y1, dy;
    logic        found;
    reading_t    rd;
    volt = (64'(code) * VREF_Q24) >> ADC_W;
    if (volt >= VTOP_Q24) begin
      volt = VSAFE_Q24;
    end
    num = ((GAIN_Q24 * volt) >> 24) + OFFS_Q24;
    res = (num << 24) / (VTOP_Q24 - volt);
    inv = (res != 0) ? ((64'd1 << 48) / res) : 64'd0;
    if (inv > 64'hFF_FFFF) begin
      inv = 64'hFF_FFFF;
    end

    // Look up the bracketing segment, clamping to the table ends
    rd.clamp = afsl_pkg::CLAMP_NONE;
    kg = cal_kg(0);
    found = 1'b0;
    if (inv <= cal_inv(0)) begin
      rd.clamp = afsl_pkg::CLAMP_LOW;
    end else if (inv >= cal_inv(CAL_POINTS - 1)) begin
      rd.clamp = afsl_pkg::CLAMP_HIGH;
      kg = cal_kg(CAL_POINTS - 1);
    end else begin
      for (int unsigned i = 0; i + 1 < CAL_POINTS; i++) begin
        x0 = cal_inv(i);
        x1 = cal_inv(i + 1);
        if (!found && x1 > x0 && inv >= x0 && inv <= x1) begin
          found = 1'b1;
          y0 = cal_kg(i);
          y1 = cal_kg(i + 1);
          frac = ((inv - x0) << 24) / (x1 - x0);
          if (y1 >= y0) begin
            kg = y0 + ((frac * (y1 - y0)) >> 24);
          end else begin
            dy = (frac * (y0 - y1)) >> 24;
            kg = (dy >= y0) ? 64'd0 : y0 - dy;
          end
        end
      end
    end

    newton = (kg * GRAV_Q24) >> 24;
    mn = (newton * 1000) >> 24;
    if (mn > MN_LIMIT) begin
      mn = MN_LIMIT;
    end
    ohm = (res * 1000) >> 24;
    if (ohm > MOHM_LIMIT) begin
      ohm = MOHM_LIMIT;
    end
    rd.uv    = 22'((volt * 1000000) >> 24);
    rd.ohm   = 17'(ohm);
    rd.inv_r = 24'(inv);
    rd.mn    = 16'(mn);
    return rd;
  endfunction

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Offer one code after a gap, hold it until taken, then log its reading
  task automatic offer_code(logic [ADC_W-1:0] code, int unsigned gap, reading_t rd);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= IN_DATA_W'(code);
    do @(posedge clk_i); while (!s_ready);
    readings_q.push_back(rd);
    @(negedge clk_i);
  endtask

  // Sender: directed table, then random codes, then drain and report
  initial begin : p_send
    code_row_t        rows [DIR_ROWS];
    reading_t         rd;
    logic [ADC_W-1:0] code;
    int unsigned      gap;
    int unsigned      pick;
    bit               quiet;
    s_valid = 1'b0;
    s_data  = '0;
    quiet   = 1'b0;
    rows = '{
      '{12'd0,    1'b1, afsl_pkg::CLAMP_HIGH, 16'd49033},
      '{12'd1,    1'b1, afsl_pkg::CLAMP_HIGH, 16'd49033},
      '{12'd100,  1'b1, afsl_pkg::CLAMP_HIGH, 16'd49033},
      '{12'd4095, 1'b1, afsl_pkg::CLAMP_LOW,  16'd4903},
      '{12'd4094, 1'b1, afsl_pkg::CLAMP_LOW,  16'd4903},
      '{12'd4000, 1'b1, afsl_pkg::CLAMP_LOW,  16'd4903},
      '{12'd362,  1'b0, afsl_pkg::CLAMP_NONE, 16'd0},
      '{12'd363,  1'b0, afsl_pkg::CLAMP_NONE, 16'd0},
      '{12'd364,  1'b0, afsl_pkg::CLAMP_NONE, 16'd0},
      '{12'd1000, 1'b0, afsl_pkg::CLAMP_NONE, 16'd0},
      '{12'h555,  1'b0, afsl_pkg::CLAMP_NONE, 16'd0},
      '{12'h7FF,  1'b0, afsl_pkg::CLAMP_NONE, 16'd0},
      '{12'h800,  1'b0, afsl_pkg::CLAMP_NONE, 16'd0},
      '{12'hAAA,  1'b0, afsl_pkg::CLAMP_NONE, 16'd0},
      '{12'd3000, 1'b0, afsl_pkg::CLAMP_NONE, 16'd0},
      '{12'd3894, 1'b0, afsl_pkg::CLAMP_NONE, 16'd0},
      '{12'd3895, 1'b0, afsl_pkg::CLAMP_NONE, 16'd0}
    };
    @(posedge rst_ni);
    @(negedge clk_i);

    // Walk the directed table, typed fields override the prediction
    for (int i = 0; i < DIR_ROWS; i++) begin
      rd = linearize_code(rows[i].code);
      if (rows[i].typed) begin
        rd.clamp = rows[i].clamp;
        rd.mn    = rows[i].mn;
      end
      offer_code(rows[i].code, $urandom_range(0, 13), rd);
    end

    // Pause until every reading is back
    s_valid <= 1'b0;
    while (readings_q.size() != 0) @(negedge clk_i);

    // Random codes, weighted towards the two table ends
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        code = ADC_W'($urandom_range(330, 400));
      end else if (pick < 30) begin
        code = ADC_W'($urandom_range(3860, 3930));
      end else begin
        code = ADC_W'($urandom_range(0, 4095));
      end
      gap = quiet ? 0 : $urandom_range(0, 13);
      offer_code(code, gap, linearize_code(code));
      if (n == RANDOM_ITEMS / 2) begin
        s_valid <= 1'b0;
        while (readings_q.size() != 0) @(negedge clk_i);
      end
    end

    // Drain, then report
    s_valid <= 1'b0;
    while (readings_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && readings_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: random stalls, quiet stretches and one long hold-off
  initial begin : p_recv
    int unsigned stall;
    int unsigned taken;
    bit          quiet;
    m_ready = 1'b0;
    taken   = 0;
    quiet   = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 40 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      stall = quiet ? 0 : $urandom_range(0, 13);
      if (taken == HOLD_OFF_AT) begin
        stall = HOLD_OFF;
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_valid);
      taken++;
      @(negedge clk_i);
    end
  end

  task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Check each taken reading against the oldest one logged
  always @(posedge clk_i) begin
    reading_t rd;
    if (rst_ni && m_valid && m_ready) begin
      if (readings_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %0d",
                 $time, m_data, m_user);
        err_cnt++;
      end else begin
        rd = readings_q.pop_front();
        compare_field("voltage_uv",     rd.uv,    m_data[21:0]);
        compare_field("resistance_ohm", rd.ohm,   m_data[38:22]);
        compare_field("inv_r_q24",      rd.inv_r, m_data[62:39]);
        compare_field("force_mn",       rd.mn,    m_data[78:63]);
        compare_field("table_clamp",    rd.clamp, m_user);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    err_cnt     = 0;
    idle_cycles = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

FILE: adc_force_sensor_linearizer_unit.f
rtl/core/afsl_pkg.sv
rtl/core/adc_force_sensor_linearizer_unit.sv
rtl/core/afsl_checker.sv
sim/tb_adc_force_sensor_linearizer_unit.sv
